// ----- src/tssmh_pkg.sv -----
// Package for the tilt servo slew block: field widths, fixed constants,
// register indexes and register reset values. No dependencies.
`default_nettype none

package tssmh_pkg;

  // Default width of the tilt outputs and of the stored tilts.
  localparam int TILT_WIDTH_DEF = 12;

  // Input and configuration field widths.
  localparam int PULSE_W    = 13;
  localparam int SCALE_W    = 15;
  localparam int THRESH_W   = 12;
  localparam int STEP_W     = 8;
  localparam int DIV_W      = 8;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  // Pulse centering and the Q14 gain shift.
  localparam int PULSE_CENTER = 3000;
  localparam int SCALE_SHIFT  = 14;

  // Centered pulse, full product and the product after the Q14 shift.
  localparam int CENTER_W = PULSE_W + 1;
  localparam int PROD_W   = CENTER_W + SCALE_W + 1;
  localparam int SHIFT_W  = PROD_W - SCALE_SHIFT;

  // Register indexes in the configuration space.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FIRST_SCALE     = 4'd0,
    CFG_SECOND_SCALE    = 4'd1,
    CFG_TRANSITION_HIGH = 4'd2,
    CFG_TRANSITION_LOW  = 4'd3,
    CFG_FORWARD_TARGET  = 4'd4,
    CFG_STEP_SIZE       = 4'd5,
    CFG_UPDATE_DIVIDER  = 4'd6,
    CFG_REVERSE         = 4'd7
  } cfg_reg_t;

  // Register reset values.
  localparam logic [SCALE_W-1:0] SCALE_RESET = 15'd8192;
  localparam logic [STEP_W-1:0]  STEP_RESET  = 8'd1;
  localparam logic [DIV_W-1:0]   DIV_RESET   = 8'd1;

endpackage

`default_nettype wire

// ----- src/tilt_servo_slew_with_mode_hysteresis.sv -----
// Top level of the tilt servo slew block with hover/forward hysteresis.
// Depends on tssmh_pkg for widths, constants and register indexes.
`default_nettype none

// Each accepted input transaction is one heartbeat tick and produces exactly one
// result transaction carrying both slewed tilts and the hover flag. The block
// takes one transaction per clock cycle while the input side is not stalled. Its
// result is offered once the tick reaches the result register. There are three
// registers on the way: an input register, a multiply stage that forms the two
// saturated tilt targets, and the result register, which is also the tilt and mode state.
// Each stage holds its transaction until the next stage is free, so a waiting
// result does not keep the input side from filling the earlier stages.
// Configuration writes are always accepted and should be issued
// only while no tick is in flight.
module tilt_servo_slew_with_mode_hysteresis #(
  parameter int TILT_WIDTH = tssmh_pkg::TILT_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,

  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [tssmh_pkg::PULSE_W-1:0]         aux_pulse,
  input  logic [tssmh_pkg::PULSE_W-1:0]         trim_pulse,
  input  logic                                  radio_link,

  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [TILT_WIDTH-1:0]          first_tilt,
  output logic signed [TILT_WIDTH-1:0]          second_tilt,
  output logic                                  hovering,

  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tssmh_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tssmh_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import tssmh_pkg::*;

  // Working width for averaging, comparing, stepping and saturating. It
  // holds the shifted product, a negated average and a target plus a step.
  localparam int DW = (TILT_WIDTH + 2 > SHIFT_W) ? TILT_WIDTH + 2 : SHIFT_W;
  localparam logic signed [DW-1:0] TILT_MAX = DW'((2 ** (TILT_WIDTH - 1)) - 1);
  localparam logic signed [DW-1:0] TILT_MIN = DW'(-(2 ** (TILT_WIDTH - 1)));

  // Saturate a working-width value to the tilt range.
  function automatic logic signed [TILT_WIDTH-1:0] clamp_tilt(
    input logic signed [DW-1:0] v
  );
    logic signed [DW-1:0] r;
    if (v > TILT_MAX) begin
      r = TILT_MAX;
    end else if (v < TILT_MIN) begin
      r = TILT_MIN;
    end else begin
      r = v;
    end
    return TILT_WIDTH'(r);
  endfunction

  // Move a tilt one step toward its target. The hold band is
  // target <= tilt < target + step.
  function automatic logic signed [TILT_WIDTH-1:0] step_toward(
    input logic signed [TILT_WIDTH-1:0] tilt,
    input logic signed [TILT_WIDTH-1:0] target,
    input logic [STEP_W-1:0]            step
  );
    logic signed [DW-1:0] tw;
    logic signed [DW-1:0] gw;
    logic signed [DW-1:0] sw;
    logic signed [TILT_WIDTH-1:0] r;
    tw = DW'(tilt);
    gw = DW'(target);
    sw = DW'(signed'({1'b0, step}));
    if (tw >= gw + sw) begin
      r = TILT_WIDTH'(tw - sw);
    end else if (tw < gw) begin
      r = clamp_tilt(tw + sw);
    end else begin
      r = tilt;
    end
    return r;
  endfunction

  // Configuration registers.
  logic [SCALE_W-1:0]         first_scale;
  logic [SCALE_W-1:0]         second_scale;
  logic signed [THRESH_W-1:0] transition_high;
  logic signed [THRESH_W-1:0] transition_low;
  logic signed [THRESH_W-1:0] forward_target;
  logic [STEP_W-1:0]          step_size;
  logic [DIV_W-1:0]           update_divider;
  logic                       reverse;

  // Pipeline registers.
  logic                         s1_valid;
  logic [PULSE_W-1:0]           s1_pulse;
  logic                         s2_valid;
  logic signed [TILT_WIDTH-1:0] s2_t1;
  logic signed [TILT_WIDTH-1:0] s2_t2;

  // State, which doubles as the result register.
  logic signed [TILT_WIDTH-1:0] tilt_one;
  logic signed [TILT_WIDTH-1:0] tilt_two;
  logic                         forward_mode;
  logic [DIV_W-1:0]             tick_phase;

  // Flow control. A stage moves forward when the next stage is empty or is
  // itself moving forward in the same cycle.
  logic s3_take;
  logic s2_take;
  logic in_take;

  assign s3_take   = s2_valid && (!out_valid || out_ready);
  assign s2_take   = s1_valid && (!s2_valid || s3_take);
  assign in_ready  = !s1_valid || s2_take;
  assign in_take   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (s2_take) begin
        s1_valid <= 1'b0;
      end
      if (s2_take) begin
        s2_valid <= 1'b1;
      end else if (s3_take) begin
        s2_valid <= 1'b0;
      end
      if (s3_take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Configuration write port.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_scale     <= SCALE_RESET;
      second_scale    <= SCALE_RESET;
      transition_high <= '0;
      transition_low  <= '0;
      forward_target  <= '0;
      step_size       <= STEP_RESET;
      update_divider  <= DIV_RESET;
      reverse         <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FIRST_SCALE:     first_scale     <= SCALE_W'(cfg_data);
        CFG_SECOND_SCALE:    second_scale    <= SCALE_W'(cfg_data);
        CFG_TRANSITION_HIGH: transition_high <= THRESH_W'(cfg_data);
        CFG_TRANSITION_LOW:  transition_low  <= THRESH_W'(cfg_data);
        CFG_FORWARD_TARGET:  forward_target  <= THRESH_W'(cfg_data);
        CFG_STEP_SIZE:       step_size       <= STEP_W'(cfg_data);
        CFG_UPDATE_DIVIDER:  update_divider  <= DIV_W'(cfg_data);
        CFG_REVERSE:         reverse         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage one: the radio flag picks the stick or the trim pulse.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pulse <= radio_link ? aux_pulse : trim_pulse;
    end
  end

  // Stage two: center the pulse, apply both Q14 gains and saturate. The
  // arithmetic shift rounds toward minus infinity.
  logic signed [CENTER_W-1:0] centered;
  logic signed [PROD_W-1:0]   prod_one;
  logic signed [PROD_W-1:0]   prod_two;
  logic signed [SHIFT_W-1:0]  shift_one;
  logic signed [SHIFT_W-1:0]  shift_two;

  always_comb begin
    centered  = CENTER_W'(signed'({1'b0, s1_pulse})) - CENTER_W'(PULSE_CENTER);
    prod_one  = PROD_W'(centered) * PROD_W'(signed'({1'b0, first_scale}));
    prod_two  = PROD_W'(centered) * PROD_W'(signed'({1'b0, second_scale}));
    shift_one = SHIFT_W'(prod_one >>> SCALE_SHIFT);
    shift_two = SHIFT_W'(prod_two >>> SCALE_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      s2_t1 <= clamp_tilt(DW'(shift_one));
      s2_t2 <= clamp_tilt(DW'(shift_two));
    end
  end

  // Stage three: average the targets toward zero, run the hysteresis, pick
  // the targets and slew the stored tilts on update ticks.
  logic signed [DW-1:0]         tgt_sum;
  logic signed [DW-1:0]         tgt_sum_adj;
  logic signed [DW-1:0]         tgt_avg;
  logic signed [DW-1:0]         mode_level;
  logic                         forward_mode_next;
  logic signed [TILT_WIDTH-1:0] forward_clamped;
  logic signed [TILT_WIDTH-1:0] target_one;
  logic signed [TILT_WIDTH-1:0] target_two;
  logic signed [TILT_WIDTH-1:0] tilt_one_next;
  logic signed [TILT_WIDTH-1:0] tilt_two_next;
  logic [DIV_W-1:0]             divider_eff;
  logic [DIV_W:0]               phase_inc;
  logic [DIV_W-1:0]             tick_phase_next;

  always_comb begin
    tgt_sum     = DW'(s2_t1) + DW'(s2_t2);
    // Adding one to a negative sum makes the shift truncate toward zero.
    tgt_sum_adj = tgt_sum + DW'(signed'({1'b0, tgt_sum[DW-1]}));
    tgt_avg     = tgt_sum_adj >>> 1;
    mode_level  = reverse ? -tgt_avg : tgt_avg;

    // The clear is checked after the set, so it wins when both thresholds hit.
    forward_mode_next = forward_mode;
    if (mode_level >= DW'(transition_high)) begin
      forward_mode_next = 1'b1;
    end
    if (mode_level < DW'(transition_low)) begin
      forward_mode_next = 1'b0;
    end

    forward_clamped = clamp_tilt(DW'(forward_target));
    target_one      = forward_mode_next ? forward_clamped : s2_t1;
    target_two      = forward_mode_next ? forward_clamped : s2_t2;

    if (tick_phase == '0) begin
      tilt_one_next = step_toward(tilt_one, target_one, step_size);
      tilt_two_next = step_toward(tilt_two, target_two, step_size);
    end else begin
      tilt_one_next = tilt_one;
      tilt_two_next = tilt_two;
    end

    // A divider of zero acts as one, and a phase left above a lowered
    // divider wraps on the next tick.
    divider_eff     = (update_divider == '0) ? DIV_W'(1) : update_divider;
    phase_inc       = {1'b0, tick_phase} + (DIV_W + 1)'(1);
    tick_phase_next = (phase_inc >= {1'b0, divider_eff}) ? '0 : phase_inc[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tilt_one     <= '0;
      tilt_two     <= '0;
      forward_mode <= 1'b0;
      tick_phase   <= '0;
    end else if (s3_take) begin
      tilt_one     <= tilt_one_next;
      tilt_two     <= tilt_two_next;
      forward_mode <= forward_mode_next;
      tick_phase   <= tick_phase_next;
    end
  end

  assign first_tilt  = tilt_one;
  assign second_tilt = tilt_two;
  assign hovering    = !forward_mode;

`ifndef SYNTHESIS
  // The state moves only when a tick enters the result register.
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !s3_take |=> $stable(tilt_one) && $stable(tilt_two) &&
                 $stable(forward_mode) && $stable(tick_phase))
    else $error("tilt state changed without a tick");

  // The input side stalls only when every stage is full.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && s2_valid && out_valid)
    else $error("input stalled with a free stage");

  // After a tick the phase is zero or below the divider in use.
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    s3_take && !cfg_valid |=>
      (tick_phase == '0) || ({1'b0, tick_phase} < {1'b0, update_divider}))
    else $error("tick phase beyond divider");
`endif

endmodule

`default_nettype wire
